/* sv/sci_pkg.sv */
// ----------------------------------------------------------------------------
// sci_pkg
// Types, codes and constants for the stepper command interlock controller.
// ----------------------------------------------------------------------------
package sci_pkg;

  // Default timer width and register widths
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int REG_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int PULSE_W         = 16;

  // Register reset values
  localparam logic [REG_W-1:0] MOVE_HALF_RST  = 16'd800;
  localparam logic [REG_W-1:0] EXT_HALF_RST   = 16'd100;
  localparam logic [REG_W-1:0] EXT_TOTAL_RST  = 16'd3200;

  // Command characters (upper case), lower-case range bounds and case offset
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_U = 8'h55;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_Z = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'd32;

  // Input op codes
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_BACK = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BUSY    = 3'd1,
    ST_MOVING  = 3'd2,
    ST_INVALID = 3'd3,
    ST_HELP    = 3'd4,
    ST_TICK    = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOVE_HALF = 2'd0,
    CFG_EXT_HALF  = 2'd1,
    CFG_EXT_TOTAL = 2'd2
  } cfg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic [REG_W-1:0] move_half;
    logic [REG_W-1:0] ext_half;
    logic [REG_W-1:0] ext_total;
  } cfg_t;

  // One input beat
  typedef struct packed {
    logic       op;
    logic [7:0] cmd_byte;
  } item_t;

  // One result beat
  typedef struct packed {
    logic    move_dir_level;
    logic    move_step_level;
    logic    extend_dir_level;
    logic    extend_step_level;
    logic    led_level;
    mode_t   move_mode;
    logic    extend_active;
    logic    stop_latched;
    status_t status;
  } result_t;

endpackage

/* sv/sci_in_if.sv */
// ----------------------------------------------------------------------------
// sci_in_if
// Input channel: command byte or tick beats.
// ----------------------------------------------------------------------------
interface sci_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] cmd_byte;

  modport source (output valid, op, cmd_byte, input ready);
  modport sink   (input valid, op, cmd_byte, output ready);
endinterface

/* sv/sci_out_if.sv */
// ----------------------------------------------------------------------------
// sci_out_if
// Result channel: pin levels, mode and status per beat.
// ----------------------------------------------------------------------------
interface sci_out_if;
  logic       valid;
  logic       ready;
  logic       move_dir_level;
  logic       move_step_level;
  logic       extend_dir_level;
  logic       extend_step_level;
  logic       led_level;
  logic [1:0] move_mode;
  logic       extend_active;
  logic       stop_latched;
  logic [2:0] status;

  modport source (output valid, move_dir_level, move_step_level, extend_dir_level,
                  extend_step_level, led_level, move_mode, extend_active,
                  stop_latched, status, input ready);
  modport sink   (input valid, move_dir_level, move_step_level, extend_dir_level,
                  extend_step_level, led_level, move_mode, extend_active,
                  stop_latched, status, output ready);
endinterface

/* sv/sci_cfg_if.sv */
// ----------------------------------------------------------------------------
// sci_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sci_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/stepper_command_interlock_controller_unit.sv */
// ----------------------------------------------------------------------------
// stepper_command_interlock_controller_unit
// Throughput: one beat per cycle unless out_bus.ready stalls the result register;
// each beat's state update is one pass through the command/tick logic between
// the input register and the result register.
// Reset: synchronous active-low rst_n clears the mode, latches, timers and
// pulse count and loads the default half periods and pulse total.
// ----------------------------------------------------------------------------
module stepper_command_interlock_controller_unit #(
  parameter int TIMER_WIDTH = sci_pkg::TIMER_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sci_in_if.sink     in_bus,
  sci_out_if.source  out_bus,
  sci_cfg_if.sink    cfg_bus
);
  import sci_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result;
  result_t out_r;
  logic    out_valid_r;
  logic    out_valid_nxt;

  // Configuration port, always ready
  assign cfg_bus.ready = 1'b1;

  sci_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_bus.valid),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .cfg      (cfg)
  );

  // Input register
  assign in_item.op       = in_bus.op;
  assign in_item.cmd_byte = in_bus.cmd_byte;

  sci_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Held beat moves on when the result register is free or draining
  assign advance = item_valid && (!out_valid_r || out_bus.ready);

  sci_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.move_dir_level    = out_r.move_dir_level;
  assign out_bus.move_step_level   = out_r.move_step_level;
  assign out_bus.extend_dir_level  = out_r.extend_dir_level;
  assign out_bus.extend_step_level = out_r.extend_step_level;
  assign out_bus.led_level         = out_r.led_level;
  assign out_bus.move_mode         = out_r.move_mode;
  assign out_bus.extend_active     = out_r.extend_active;
  assign out_bus.stop_latched      = out_r.stop_latched;
  assign out_bus.status            = out_r.status;

  // Interlock: an extension run never overlaps drive motion
  a_no_move_while_extending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.extend_active) |-> (out_r.move_mode == MODE_STOP))
    else $error("drive moving during extension run");

  // Stop latch holds the drive stopped
  a_stop_holds_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.stop_latched) |-> (out_r.move_mode == MODE_STOP))
    else $error("drive moving with stop latched");

  // Extension step line only high during a run
  a_ext_step_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.extend_step_level) |-> out_r.extend_active)
    else $error("extension step high outside a run");

  // Every processed beat lands in the result register
  a_beat_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed beat not presented");

endmodule

/* sv/sci_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sci_cfg_regs
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module sci_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [sci_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [sci_pkg::REG_W-1:0]       wr_data,
  output sci_pkg::cfg_t                   cfg
);
  import sci_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_MOVE_HALF: cfg_nxt.move_half = wr_data;
        CFG_EXT_HALF:  cfg_nxt.ext_half  = wr_data;
        CFG_EXT_TOTAL: cfg_nxt.ext_total = wr_data;
        default:       cfg_nxt = cfg_r;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.move_half <= MOVE_HALF_RST;
      cfg_r.ext_half  <= EXT_HALF_RST;
      cfg_r.ext_total <= EXT_TOTAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/sci_in_stage.sv */
// ----------------------------------------------------------------------------
// sci_in_stage
// Input register: captures one beat, releases it when the core advances.
// ----------------------------------------------------------------------------
module sci_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sci_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output sci_pkg::item_t item
);
  import sci_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Free slot, or the held beat leaves this cycle
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* sv/sci_core.sv */
// ----------------------------------------------------------------------------
// sci_core
// Controller state and the per-beat update for commands and ticks.
// ----------------------------------------------------------------------------
module sci_core #(
  parameter int TIMER_WIDTH = sci_pkg::TIMER_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             commit,
  input  sci_pkg::item_t   item,
  input  sci_pkg::cfg_t    cfg,
  output sci_pkg::result_t result
);
  import sci_pkg::*;

  // Compare width covers both the timer and a 16-bit half period
  localparam int CW = (TIMER_WIDTH > REG_W) ? TIMER_WIDTH : REG_W;

  mode_t                  mode_r, mode_nxt;
  logic                   busy_r, busy_nxt;
  logic                   stop_r, stop_nxt;
  logic                   retract_r, retract_nxt;
  logic                   dir_r, dir_nxt;
  logic                   lamp_r, lamp_nxt;
  logic [TIMER_WIDTH-1:0] drv_tmr_r, drv_tmr_nxt;
  logic                   drv_step_r, drv_step_nxt;
  logic [TIMER_WIDTH-1:0] ext_tmr_r, ext_tmr_nxt;
  logic                   ext_step_r, ext_step_nxt;
  logic [PULSE_W-1:0]     pulses_r, pulses_nxt;

  logic [TIMER_WIDTH-1:0] drv_inc, ext_inc;
  logic [REG_W-1:0]       drv_half, ext_half;
  logic                   drv_done, ext_done;
  logic [7:0]             ch;
  status_t                status;

  // Timer increments and half-period compares (zero half period acts as 1)
  always_comb begin
    drv_inc  = drv_tmr_r + TIMER_WIDTH'(1);
    ext_inc  = ext_tmr_r + TIMER_WIDTH'(1);
    drv_half = (cfg.move_half == '0) ? REG_W'(1) : cfg.move_half;
    ext_half = (cfg.ext_half == '0) ? REG_W'(1) : cfg.ext_half;
    drv_done = CW'(drv_inc) >= CW'(drv_half);
    ext_done = CW'(ext_inc) >= CW'(ext_half);
  end

  // Fold lower case onto upper case
  assign ch = (item.cmd_byte >= CH_LC_A && item.cmd_byte <= CH_LC_Z) ?
              (item.cmd_byte - CASE_OFS) : item.cmd_byte;

  // Next-state logic
  always_comb begin
    mode_nxt     = mode_r;
    busy_nxt     = busy_r;
    stop_nxt     = stop_r;
    retract_nxt  = retract_r;
    dir_nxt      = dir_r;
    lamp_nxt     = lamp_r;
    drv_tmr_nxt  = drv_tmr_r;
    drv_step_nxt = drv_step_r;
    ext_tmr_nxt  = ext_tmr_r;
    ext_step_nxt = ext_step_r;
    pulses_nxt   = pulses_r;
    status       = ST_TICK;

    if (item.op == OP_TICK) begin
      // Drive step pulse
      if (mode_r != MODE_STOP && !busy_r && !stop_r) begin
        if (drv_done) begin
          drv_tmr_nxt  = '0;
          drv_step_nxt = !drv_step_r;
        end else begin
          drv_tmr_nxt = drv_inc;
        end
      end else begin
        drv_tmr_nxt  = '0;
        drv_step_nxt = 1'b0;
      end
      // Extension pulse run
      if (busy_r) begin
        if (ext_done) begin
          ext_tmr_nxt = '0;
          if (ext_step_r) begin
            ext_step_nxt = 1'b0;
            pulses_nxt   = pulses_r + PULSE_W'(1);
          end else if (stop_r || pulses_r >= cfg.ext_total) begin
            busy_nxt     = 1'b0;
            ext_step_nxt = 1'b0;
          end else begin
            ext_step_nxt = 1'b1;
          end
        end else begin
          ext_tmr_nxt = ext_inc;
        end
      end else begin
        ext_tmr_nxt  = '0;
        ext_step_nxt = 1'b0;
      end
    end else begin
      // Command decode
      unique case (ch)
        CH_F, CH_B: begin
          if (busy_r) begin
            status = ST_BUSY;
          end else begin
            mode_nxt = (ch == CH_F) ? MODE_FWD : MODE_BACK;
            stop_nxt = 1'b0;
            dir_nxt  = (ch == CH_F);
            lamp_nxt = 1'b1;
            status   = ST_OK;
          end
        end
        CH_S: begin
          mode_nxt = MODE_STOP;
          lamp_nxt = 1'b0;
          status   = ST_OK;
        end
        CH_U, CH_D: begin
          if (busy_r) begin
            status = ST_BUSY;
          end else if (mode_r != MODE_STOP) begin
            status = ST_MOVING;
          end else begin
            busy_nxt     = 1'b1;
            retract_nxt  = (ch == CH_D);
            ext_tmr_nxt  = '0;
            ext_step_nxt = 1'b0;
            pulses_nxt   = '0;
            status       = ST_OK;
          end
        end
        CH_E: begin
          stop_nxt     = 1'b1;
          mode_nxt     = MODE_STOP;
          lamp_nxt     = 1'b0;
          busy_nxt     = 1'b0;
          ext_step_nxt = 1'b0;
          ext_tmr_nxt  = '0;
          status       = ST_OK;
        end
        CH_H:    status = ST_HELP;
        default: status = ST_INVALID;
      endcase
    end
  end

  // State registers, updated once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_STOP;
      busy_r     <= 1'b0;
      stop_r     <= 1'b0;
      retract_r  <= 1'b0;
      dir_r      <= 1'b0;
      lamp_r     <= 1'b0;
      drv_tmr_r  <= '0;
      drv_step_r <= 1'b0;
      ext_tmr_r  <= '0;
      ext_step_r <= 1'b0;
      pulses_r   <= '0;
    end else if (commit) begin
      mode_r     <= mode_nxt;
      busy_r     <= busy_nxt;
      stop_r     <= stop_nxt;
      retract_r  <= retract_nxt;
      dir_r      <= dir_nxt;
      lamp_r     <= lamp_nxt;
      drv_tmr_r  <= drv_tmr_nxt;
      drv_step_r <= drv_step_nxt;
      ext_tmr_r  <= ext_tmr_nxt;
      ext_step_r <= ext_step_nxt;
      pulses_r   <= pulses_nxt;
    end
  end

  // Result reflects the state after this beat
  always_comb begin
    result.move_dir_level    = dir_nxt;
    result.move_step_level   = drv_step_nxt;
    result.extend_dir_level  = retract_nxt;
    result.extend_step_level = ext_step_nxt;
    result.led_level         = lamp_nxt;
    result.move_mode         = mode_nxt;
    result.extend_active     = busy_nxt;
    result.stop_latched      = stop_nxt;
    result.status            = status;
  end

endmodule
